// ===== rtl/usbep_pkg.sv =====
package usbep_pkg;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] xfer_size;
    logic [3:0]  hw_chain_packets;
    logic [10:0] hw_last_len;
    logic [10:0] hw_ep0_rx_len;
    logic [4:0]  hw_rx_seq;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  ep_state_out;
    logic [3:0]  chain_packets;
    logic [10:0] last_packet_len;
    logic [4:0]  seq_out;
    logic        bank_out;
    logic [15:0] done_size;
    logic        done_flag;
    logic [15:0] max_xfer;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic fin;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_stat_t;

  typedef enum logic [2:0] {
    REQ_OPEN     = 3'd0,
    REQ_CLOSE    = 3'd1,
    REQ_XFER     = 3'd2,
    REQ_STALL    = 3'd3,
    REQ_CLEAR    = 3'd4,
    REQ_COMPLETE = 3'd5,
    REQ_SWITCH   = 3'd6,
    REQ_BAD      = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    CFG_CTRL0   = 3'd0,
    CFG_DIR_IN  = 3'd1,
    CFG_KIND    = 3'd2,
    CFG_MAXPKT  = 3'd3,
    CFG_BURST   = 3'd4,
    CFG_BUFFER  = 3'd5,
    CFG_DOUBLE  = 3'd6,
    CFG_UNUSED  = 3'd7
  } cfg_idx_t;

  localparam logic [2:0] STAT_OK     = 3'd0;
  localparam logic [2:0] STAT_BUSY   = 3'd1;
  localparam logic [2:0] STAT_NOBUF  = 3'd2;
  localparam logic [2:0] STAT_ARG    = 3'd3;
  localparam logic [2:0] STAT_FAILED = 3'd4;

  localparam logic [1:0] EP_DISABLED = 2'd0;
  localparam logic [1:0] EP_IDLE     = 2'd1;
  localparam logic [1:0] EP_BUSY     = 2'd2;
  localparam logic [1:0] EP_STALLED  = 2'd3;

  localparam logic [1:0] KIND_CONTROL = 2'd0;
  localparam logic [1:0] KIND_BULK    = 2'd2;

  localparam logic [10:0] PKT_CONTROL = 11'd512;
  localparam logic [10:0] PKT_BULK    = 11'd1024;
  localparam logic [10:0] PKT_RESET   = 11'd64;

  localparam logic [7:0] BURST_LIMIT = 8'd16;
  localparam logic [7:0] CHAIN_LIMIT = 8'd15;

endpackage

// ===== rtl/usbep_div.sv =====
module usbep_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [10:0] divisor,
  output logic        done,
  output logic [15:0] quotient,
  output logic [10:0] remainder
);

  logic        running;
  logic [3:0]  cnt;
  logic [11:0] rem_sh;
  logic [11:0] rem_diff;
  logic        ge;

  assign rem_sh   = {remainder, quotient[15]};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign rem_diff = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= running && (cnt == 4'd15);
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (running) begin
      quotient  <= {quotient[14:0], ge};
      remainder <= ge ? rem_diff[10:0] : rem_sh[10:0];
    end
  end

endmodule

// ===== rtl/usbep_ctrl.sv =====
module usbep_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output usbep_pkg::ctl_cmd_t cmd,
  input  usbep_pkg::dp_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_full;
  logic   out_free;

  assign in_ready = !in_full;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.load   = in_valid && !in_full;
    cmd.exec   = (state == S_EXEC);
    cmd.fin    = (state == S_FIN);
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_full && out_free) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = stat.need_div ? S_DIV : S_FIN;
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_FIN;
      end
      S_FIN: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        in_full <= 1'b1;
      end else if (cmd.exec) begin
        in_full <= 1'b0;
      end
      if (cmd.fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/usbep_dp.sv =====
module usbep_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  usbep_pkg::in_item_t  in_data,
  output usbep_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  usbep_pkg::ctl_cmd_t  cmd,
  output usbep_pkg::dp_stat_t  stat
);

  usbep_pkg::in_item_t in_q;

  // configuration
  logic        is_control_zero;
  logic        dir_in;
  logic [1:0]  ep_kind;
  logic [10:0] max_packet_cfg;
  logic [7:0]  max_burst;
  logic [15:0] buffer_bytes;
  logic        want_double;

  // endpoint state
  logic [1:0]  ep_state;
  logic [4:0]  seq_num;
  logic        active_bank;
  logic        use_double;
  logic [15:0] bank_bytes;
  logic [10:0] packet_bytes;
  logic [15:0] armed_size;

  // per-transaction results
  logic [2:0]  status_r;
  logic [15:0] dsize_r;
  logic        dflag_r;
  logic [3:0]  chain_r;
  logic [10:0] last_r;
  logic        use_div_r;

  // next values
  logic [1:0]  ep_state_next;
  logic [4:0]  seq_num_next;
  logic        active_bank_next;
  logic        use_double_next;
  logic [15:0] bank_bytes_next;
  logic [10:0] packet_bytes_next;
  logic [15:0] armed_size_next;
  logic [2:0]  status_next;
  logic [15:0] dsize_next;
  logic        dflag_next;
  logic [3:0]  chain_next;
  logic [10:0] last_next;
  logic        need_div;

  logic [7:0]  burst_clamp;
  logic [3:0]  chain_max;
  logic [14:0] window;
  logic [15:0] max_xfer_cur;
  logic [10:0] pkt_open;
  logic        dbl_open;
  logic [14:0] hw_prod;
  logic [15:0] hw_size;

  logic        div_done;
  logic [15:0] div_q;
  logic [10:0] div_r;
  logic [16:0] div_ceil;
  logic [3:0]  div_chain;
  logic [10:0] div_last;

  usbep_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.exec && need_div),
    .dividend  (in_q.xfer_size),
    .divisor   (packet_bytes),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign stat.need_div = need_div;
  assign stat.div_done = div_done;

  always_comb begin
    burst_clamp = (max_burst == 8'd0) ? 8'd1 : max_burst;
    if (burst_clamp > usbep_pkg::BURST_LIMIT) burst_clamp = usbep_pkg::BURST_LIMIT;
    chain_max = (burst_clamp < usbep_pkg::CHAIN_LIMIT) ? burst_clamp[3:0]
                                                       : usbep_pkg::CHAIN_LIMIT[3:0];
    window = 15'(packet_bytes * chain_max);
    if (is_control_zero) begin
      max_xfer_cur = {5'd0, packet_bytes};
    end else begin
      max_xfer_cur = (bank_bytes < {1'b0, window}) ? bank_bytes : {1'b0, window};
    end
  end

  always_comb begin
    if (ep_kind == usbep_pkg::KIND_CONTROL) pkt_open = usbep_pkg::PKT_CONTROL;
    else if (ep_kind == usbep_pkg::KIND_BULK) pkt_open = usbep_pkg::PKT_BULK;
    else pkt_open = max_packet_cfg;
    dbl_open = !is_control_zero && want_double &&
               ({1'b0, buffer_bytes} >= {5'd0, pkt_open, 1'b0});
    hw_prod = 15'((in_q.hw_chain_packets - 4'd1) * packet_bytes);
    hw_size = 16'({1'b0, hw_prod} + {5'd0, in_q.hw_last_len});
  end

  always_comb begin
    ep_state_next     = ep_state;
    seq_num_next      = seq_num;
    active_bank_next  = active_bank;
    use_double_next   = use_double;
    bank_bytes_next   = bank_bytes;
    packet_bytes_next = packet_bytes;
    armed_size_next   = armed_size;
    status_next       = usbep_pkg::STAT_OK;
    dsize_next        = '0;
    dflag_next        = 1'b0;
    chain_next        = '0;
    last_next         = '0;
    need_div          = 1'b0;
    unique case (usbep_pkg::req_t'(in_q.req_type))
      usbep_pkg::REQ_OPEN: begin
        packet_bytes_next = pkt_open;
        use_double_next   = dbl_open;
        bank_bytes_next   = dbl_open ? {1'b0, buffer_bytes[15:1]} : buffer_bytes;
        active_bank_next  = 1'b0;
        seq_num_next      = '0;
        ep_state_next     = usbep_pkg::EP_IDLE;
      end
      usbep_pkg::REQ_CLOSE: begin
        active_bank_next = 1'b0;
        ep_state_next    = usbep_pkg::EP_DISABLED;
      end
      usbep_pkg::REQ_XFER: begin
        if (ep_state == usbep_pkg::EP_BUSY) begin
          status_next = usbep_pkg::STAT_BUSY;
        end else if (in_q.xfer_size > bank_bytes) begin
          status_next = usbep_pkg::STAT_NOBUF;
        end else if (in_q.xfer_size > max_xfer_cur) begin
          status_next = usbep_pkg::STAT_ARG;
        end else begin
          armed_size_next = in_q.xfer_size;
          ep_state_next   = usbep_pkg::EP_BUSY;
          if (!is_control_zero) begin
            if (dir_in && in_q.xfer_size == 16'd0) begin
              chain_next = '0;
            end else if (packet_bytes == 11'd0 || in_q.xfer_size == 16'd0) begin
              chain_next = 4'd1;
            end else begin
              need_div = 1'b1;
            end
          end
        end
      end
      usbep_pkg::REQ_STALL: begin
        if (ep_state != usbep_pkg::EP_IDLE &&
            !(is_control_zero && ep_state == usbep_pkg::EP_BUSY)) begin
          status_next = usbep_pkg::STAT_BUSY;
        end else begin
          ep_state_next = usbep_pkg::EP_STALLED;
        end
      end
      usbep_pkg::REQ_CLEAR: begin
        if (ep_state != usbep_pkg::EP_STALLED) begin
          status_next = usbep_pkg::STAT_FAILED;
        end else begin
          seq_num_next     = '0;
          active_bank_next = 1'b0;
          ep_state_next    = usbep_pkg::EP_IDLE;
        end
      end
      usbep_pkg::REQ_COMPLETE: begin
        if (dir_in) dsize_next = armed_size;
        else if (in_q.xfer_size != 16'd0) dsize_next = in_q.xfer_size;
        else if (is_control_zero) dsize_next = {5'd0, in_q.hw_ep0_rx_len};
        else if (in_q.hw_chain_packets <= 4'd1) dsize_next = {5'd0, in_q.hw_last_len};
        else dsize_next = hw_size;
        if (is_control_zero) seq_num_next = seq_num + 5'd1;
        else if (dir_in) active_bank_next = active_bank ^ use_double;
        else seq_num_next = in_q.hw_rx_seq;
        dflag_next    = 1'b1;
        ep_state_next = usbep_pkg::EP_IDLE;
      end
      usbep_pkg::REQ_SWITCH: begin
        if (use_double && !is_control_zero) active_bank_next = !active_bank;
      end
      usbep_pkg::REQ_BAD: begin
        status_next = usbep_pkg::STAT_ARG;
      end
      default: status_next = usbep_pkg::STAT_ARG;
    endcase
  end

  always_comb begin
    div_ceil  = {1'b0, div_q} + {16'd0, (div_r != 11'd0)};
    div_chain = (div_ceil > {13'd0, chain_max}) ? chain_max : div_ceil[3:0];
    div_last  = (div_r == 11'd0) ? packet_bytes : div_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_control_zero <= 1'b0;
      dir_in          <= 1'b0;
      ep_kind         <= usbep_pkg::KIND_CONTROL;
      max_packet_cfg  <= usbep_pkg::PKT_RESET;
      max_burst       <= 8'd1;
      buffer_bytes    <= '0;
      want_double     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (usbep_pkg::cfg_idx_t'(cfg_index))
        usbep_pkg::CFG_CTRL0:  is_control_zero <= cfg_data[0];
        usbep_pkg::CFG_DIR_IN: dir_in          <= cfg_data[0];
        usbep_pkg::CFG_KIND:   ep_kind         <= cfg_data[1:0];
        usbep_pkg::CFG_MAXPKT: max_packet_cfg  <= cfg_data[10:0];
        usbep_pkg::CFG_BURST:  max_burst       <= cfg_data[7:0];
        usbep_pkg::CFG_BUFFER: buffer_bytes    <= cfg_data;
        usbep_pkg::CFG_DOUBLE: want_double     <= cfg_data[0];
        usbep_pkg::CFG_UNUSED: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ep_state     <= usbep_pkg::EP_DISABLED;
      seq_num      <= '0;
      active_bank  <= 1'b0;
      use_double   <= 1'b0;
      bank_bytes   <= '0;
      packet_bytes <= '0;
      armed_size   <= '0;
    end else if (cmd.exec) begin
      ep_state     <= ep_state_next;
      seq_num      <= seq_num_next;
      active_bank  <= active_bank_next;
      use_double   <= use_double_next;
      bank_bytes   <= bank_bytes_next;
      packet_bytes <= packet_bytes_next;
      armed_size   <= armed_size_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_q <= in_data;
    end
    if (cmd.exec) begin
      status_r  <= status_next;
      dsize_r   <= dsize_next;
      dflag_r   <= dflag_next;
      chain_r   <= chain_next;
      last_r    <= last_next;
      use_div_r <= need_div;
    end
    if (cmd.fin) begin
      out_data.status          <= status_r;
      out_data.ep_state_out    <= ep_state;
      out_data.chain_packets   <= use_div_r ? div_chain : chain_r;
      out_data.last_packet_len <= use_div_r ? div_last : last_r;
      out_data.seq_out         <= seq_num;
      out_data.bank_out        <= active_bank;
      out_data.done_size       <= dsize_r;
      out_data.done_flag       <= dflag_r;
      out_data.max_xfer        <= max_xfer_cur;
    end
  end

endmodule

// ===== rtl/usb_ss_endpoint_transfer_control.sv =====
// Each input transaction is captured, then executed (EXEC), and its result is
// registered and made valid (FIN); a transfer that arms a packet chain also runs
// a bit-serial ceil-divide by the packet size (DIV, one quotient bit per cycle).
// Throughput: one request in flight; the next is buffered while a result waits.
// Reset (rst, synchronous): endpoint disabled, sequence, bank and sizes zero,
// registers at defaults (max packet 64, burst 1).
module usb_ss_endpoint_transfer_control (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  usbep_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output usbep_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  usbep_pkg::ctl_cmd_t cmd;
  usbep_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  usbep_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  usbep_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
